// ===== sv/imcol_pkg.sv =====
// shared constants, codes and types of the window gather block
package imcol_pkg;

   // image and kernel limits
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int MAX_DEPTH  = 4;
   localparam int MAX_KERNEL = 7;

   // field widths
   localparam int CH_W    = 2;
   localparam int ROW_W   = 6;
   localparam int COL_W   = 6;
   localparam int WORD_W  = 32;
   localparam int SIZE_W  = 7;
   localparam int DEPTH_W = 3;
   localparam int KER_W   = 3;
   localparam int ADDR_W  = CH_W + ROW_W + COL_W;
   localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT * MAX_DEPTH;
   // window position with a sign bit: centre plus offset stays in -3..66
   localparam int POS_W   = 8;

   // stream payload widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_DEPTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 3'd4;

   // register reset values
   localparam logic [SIZE_W-1:0]  RST_IMAGE_WIDTH   = 7'd32;
   localparam logic [SIZE_W-1:0]  RST_IMAGE_HEIGHT  = 7'd32;
   localparam logic [DEPTH_W-1:0] RST_IMAGE_DEPTH   = 3'd1;
   localparam logic [KER_W-1:0]   RST_KERNEL_WIDTH  = 3'd3;
   localparam logic [KER_W-1:0]   RST_KERNEL_HEIGHT = 3'd3;

   // command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_GATHER = 1'b1;

   // command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // effective (saturated) configuration
   typedef struct packed {
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [DEPTH_W-1:0] depth;
      logic [KER_W-1:0]   kw;
      logic [KER_W-1:0]   kh;
   } cfg_type;

   // classified command passed from front to back
   typedef struct packed {
      logic              gather;
      logic              ch_ok;
      logic [CH_W-1:0]   channel;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [WORD_W-1:0] word;
   } job_type;

endpackage

// ===== sv/imcol_front.sv =====
// front end: accepts request transactions and classifies them for the queue
module imcol_front (
   input  imcol_pkg::cfg_type                  cfg,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: channel[1:0], row[7:2], col[13:8], pixel_value[45:14], zero fill
   input  logic [imcol_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: command[0]
   input  logic                                req_tuser,
   input  logic                                q_full,
   output logic                                q_push,
   output imcol_pkg::job_type                  q_job
);
   import imcol_pkg::*;

   logic [CH_W-1:0]   channel;
   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   logic [WORD_W-1:0] word;
   logic              ch_ok;
   logic              write_inside;
   logic              keep;

   // unpack the payload
   assign channel = req_tdata[CH_W-1:0];
   assign row     = req_tdata[CH_W+ROW_W-1:CH_W];
   assign col     = req_tdata[CH_W+ROW_W+COL_W-1:CH_W+ROW_W];
   assign word    = req_tdata[ADDR_W+WORD_W-1:ADDR_W];

   // range checks against the image in use
   assign ch_ok        = {1'b0, channel} < cfg.depth;
   assign write_inside = ch_ok && ({1'b0, row} < cfg.height) && ({1'b0, col} < cfg.width);

   // drop writes outside the image and gathers with an empty kernel
   always_comb begin
      if (req_tuser == CMD_GATHER) begin
         keep = (cfg.kw != '0) && (cfg.kh != '0);
      end else begin
         keep = write_inside;
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full && keep;

   assign q_job.gather  = (req_tuser == CMD_GATHER);
   assign q_job.ch_ok   = ch_ok;
   assign q_job.channel = channel;
   assign q_job.row     = row;
   assign q_job.col     = col;
   assign q_job.word    = word;

endmodule

// ===== sv/imcol_fifo.sv =====
// short command queue between front and back
module imcol_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  imcol_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output imcol_pkg::job_type pop_job
);
   import imcol_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/imcol_back.sv =====
// back end: pixel store, window sequencer and response register
module imcol_back (
   input  logic                             clock,
   input  logic                             reset,
   input  imcol_pkg::cfg_type               cfg,
   input  logic                             q_valid,
   input  imcol_pkg::job_type               q_job,
   output logic                             q_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: element_value[31:0]
   output logic [imcol_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: padded[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import imcol_pkg::*;

   logic [WORD_W-1:0] store [STORE_WORDS];

   // sequencer state
   logic              busy_ff, busy_in;
   logic [KER_W-1:0]  m_ff, m_in;
   logic [KER_W-1:0]  n_ff, n_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic              ch_ok_ff, ch_ok_in;

   // response register
   logic              out_valid_ff, out_valid_in;
   logic              out_pad_ff, out_pad_in;
   logic              out_last_ff, out_last_in;
   logic [WORD_W-1:0] rd_data_ff;

   logic              advance;
   logic              emit;
   logic              elem_last;
   logic              pop_ok;
   logic              store_we;
   logic              store_re;
   logic [POS_W-1:0]  y_pos;
   logic [POS_W-1:0]  x_pos;
   logic              y_ok;
   logic              x_ok;
   logic              pos_ok;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   // window position of the current element; bit POS_W-1 marks a negative value
   assign y_pos = {2'b00, row_ff} + {{(POS_W-KER_W){1'b0}}, m_ff}
                - {{(POS_W-KER_W+1){1'b0}}, cfg.kh[KER_W-1:1]};
   assign x_pos = {2'b00, col_ff} + {{(POS_W-KER_W){1'b0}}, n_ff}
                - {{(POS_W-KER_W+1){1'b0}}, cfg.kw[KER_W-1:1]};
   assign y_ok   = !y_pos[POS_W-1] && (y_pos[SIZE_W-1:0] < cfg.height);
   assign x_ok   = !x_pos[POS_W-1] && (x_pos[SIZE_W-1:0] < cfg.width);
   assign pos_ok = ch_ok_ff && y_ok && x_ok;
   assign rd_addr = {ch_ff, y_pos[ROW_W-1:0], x_pos[COL_W-1:0]};
   assign wr_addr = {q_job.channel, q_job.row, q_job.col};

   // handshake and sequencing control
   assign advance   = !out_valid_ff || rsp_tready;
   assign emit      = busy_ff && advance;
   assign elem_last = (m_ff == cfg.kh - 1'b1) && (n_ff == cfg.kw - 1'b1);
   assign pop_ok    = !busy_ff || (emit && elem_last);
   assign q_pop     = q_valid && pop_ok;
   assign store_we  = q_pop && !q_job.gather;
   assign store_re  = emit && pos_ok;

   // window counters, row-major
   always_comb begin
      busy_in  = busy_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      ch_in    = ch_ff;
      ch_ok_in = ch_ok_ff;
      if (emit) begin
         if (n_ff == cfg.kw - 1'b1) begin
            n_in = '0;
            m_in = m_ff + 1'b1;
         end else begin
            n_in = n_ff + 1'b1;
         end
         if (elem_last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop && q_job.gather) begin
         busy_in  = 1'b1;
         m_in     = '0;
         n_in     = '0;
         row_in   = q_job.row;
         col_in   = q_job.col;
         ch_in    = q_job.channel;
         ch_ok_in = q_job.ch_ok;
      end
   end

   // response register next state
   always_comb begin
      out_valid_in = out_valid_ff;
      out_pad_in   = out_pad_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = emit;
         out_pad_in   = !pos_ok;
         out_last_in  = elem_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         m_ff         <= '0;
         n_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         m_ff         <= m_in;
         n_ff         <= n_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      ch_ff       <= ch_in;
      ch_ok_ff    <= ch_ok_in;
      out_pad_ff  <= out_pad_in;
      out_last_ff <= out_last_in;
   end

   // pixel store: one write and one registered read per cycle, read sees old data
   always_ff @(posedge clock) begin
      if (store_we) begin
         store[wr_addr] <= q_job.word;
      end
      if (store_re) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pad_ff ? '0 : rd_data_ff;
   assign rsp_tuser  = out_pad_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== sv/image_to_columns_window_gather_core.sv =====
// top level: csr registers, front end, command queue and back end
// a gather's first element passes the queue, the sequencer and the response register
// a gather yields kernel_height*kernel_width elements, one per cycle unless stalled
// pixel writes wait while a gather runs; the four-entry queue absorbs bursts
// reset: registers return to their defaults and the queue empties; the pixel
// store is not cleared and holds undefined words until written
module image_to_columns_window_gather_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: channel[1:0], row[7:2], col[13:8], pixel_value[45:14], zero fill
   input  logic [imcol_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: command[0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: element_value[31:0]
   output logic [imcol_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: padded[0]
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [imcol_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [imcol_pkg::CSR_DATA_W-1:0] csr_data
);
   import imcol_pkg::*;

   logic [SIZE_W-1:0]  width_ff, width_in;
   logic [SIZE_W-1:0]  height_ff, height_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic [KER_W-1:0]   kw_ff, kw_in;
   logic [KER_W-1:0]   kh_ff, kh_in;
   cfg_type            cfg;
   logic               q_full;
   logic               q_push;
   job_type            q_push_job;
   logic               q_pop;
   logic               q_valid;
   job_type            q_pop_job;

   // csr write decode
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      depth_in  = depth_ff;
      kw_in     = kw_ff;
      kh_in     = kh_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:   width_in  = csr_data;
            CSR_IMAGE_HEIGHT:  height_in = csr_data;
            CSR_IMAGE_DEPTH:   depth_in  = csr_data[DEPTH_W-1:0];
            CSR_KERNEL_WIDTH:  kw_in     = csr_data[KER_W-1:0];
            CSR_KERNEL_HEIGHT: kh_in     = csr_data[KER_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         depth_ff  <= RST_IMAGE_DEPTH;
         kw_ff     <= RST_KERNEL_WIDTH;
         kh_ff     <= RST_KERNEL_HEIGHT;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         depth_ff  <= depth_in;
         kw_ff     <= kw_in;
         kh_ff     <= kh_in;
      end
   end

   // saturate sizes to the store limits
   assign cfg.width  = (width_ff > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_ff;
   assign cfg.height = (height_ff > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_ff;
   assign cfg.depth  = (depth_ff > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : depth_ff;
   assign cfg.kw     = (kw_ff > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kw_ff;
   assign cfg.kh     = (kh_ff > KER_W'(MAX_KERNEL)) ? KER_W'(MAX_KERNEL) : kh_ff;

   imcol_front u_front (
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_push_job)
   );

   imcol_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_pop_job)
   );

   imcol_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_job      (q_pop_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the zero-padded im2col window gather core
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import imcol_pkg::*;

   localparam int CYCLE_LIMIT  = 20000000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 10;

   // one expected window element
   typedef struct {
      logic [WORD_W-1:0] value;
      logic              padded;
      logic              is_last;
   } element_type;

   // shadow of the pixel store and registers, predicts window elements
   class gather_checker;
      logic [WORD_W-1:0]  pixel_copy [STORE_WORDS];
      bit                 pixel_written [STORE_WORDS];
      logic [SIZE_W-1:0]  reg_width;
      logic [SIZE_W-1:0]  reg_height;
      logic [DEPTH_W-1:0] reg_depth;
      logic [KER_W-1:0]   reg_kw;
      logic [KER_W-1:0]   reg_kh;
      int                 w, h, d, kw, kh;
      element_type        expected_elements [$];
      int                 errors;

      function new();
         reg_width  = RST_IMAGE_WIDTH;
         reg_height = RST_IMAGE_HEIGHT;
         reg_depth  = RST_IMAGE_DEPTH;
         reg_kw     = RST_KERNEL_WIDTH;
         reg_kh     = RST_KERNEL_HEIGHT;
         errors     = 0;
         update_sizes();
      endfunction

      // saturate register values to the block limits
      function void update_sizes();
         w  = (reg_width > MAX_WIDTH) ? MAX_WIDTH : int'(reg_width);
         h  = (reg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(reg_height);
         d  = (reg_depth > MAX_DEPTH) ? MAX_DEPTH : int'(reg_depth);
         kw = (reg_kw > MAX_KERNEL) ? MAX_KERNEL : int'(reg_kw);
         kh = (reg_kh > MAX_KERNEL) ? MAX_KERNEL : int'(reg_kh);
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_IMAGE_WIDTH:   reg_width  = val;
            CSR_IMAGE_HEIGHT:  reg_height = val;
            CSR_IMAGE_DEPTH:   reg_depth  = val[DEPTH_W-1:0];
            CSR_KERNEL_WIDTH:  reg_kw     = val[KER_W-1:0];
            CSR_KERNEL_HEIGHT: reg_kh     = val[KER_W-1:0];
            default: ;
         endcase
         update_sizes();
      endfunction

      function int addr(int ch, int y, int x);
         return (ch * MAX_HEIGHT + y) * MAX_WIDTH + x;
      endfunction

      function bit in_image(int ch, int y, int x);
         return ch < d && y >= 0 && x >= 0 && y < h && x < w;
      endfunction

      // called once per accepted command transaction
      function void note_command(logic cmd, logic [CH_W-1:0] ch, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col, logic [WORD_W-1:0] word);
         element_type e;
         int          y, x;
         if (cmd == CMD_WRITE) begin
            if (in_image(ch, row, col)) begin
               pixel_copy[addr(ch, row, col)]    = word;
               pixel_written[addr(ch, row, col)] = 1'b1;
            end
            return;
         end
         // row-major walk of the window, top-left corner offset by half the kernel
         for (int m = 0; m < kh; m++) begin
            for (int n = 0; n < kw; n++) begin
               y = int'(row) + m - kh / 2;
               x = int'(col) + n - kw / 2;
               if (in_image(ch, y, x)) begin
                  e.value  = pixel_copy[addr(ch, y, x)];
                  e.padded = 1'b0;
               end else begin
                  e.value  = '0;
                  e.padded = 1'b1;
               end
               e.is_last = (m == kh - 1) && (n == kw - 1);
               expected_elements.push_back(e);
            end
         end
      endfunction

      // called once per accepted result transaction
      function void check_element(logic [WORD_W-1:0] value, logic padded, logic is_last);
         element_type e;
         if (expected_elements.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected element: value %h padded %b last %b",
                        value, padded, is_last);
            return;
         end
         e = expected_elements.pop_front();
         if (value !== e.value || padded !== e.padded || is_last !== e.is_last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("element mismatch: expected %h/%b/%b, got %h/%b/%b",
                        e.value, e.padded, e.is_last, value, padded, is_last);
         end
      endfunction

      function int pending();
         return expected_elements.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   gather_checker sb;
   bit            no_idle    = 1'b0;
   int            stall_left = 0;
   int            cycle_count = 0;

   image_to_columns_window_gather_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // idle length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // receiver back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_element(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // one command transaction, preceded by a random gap
   task automatic send_command(input logic cmd, input logic [CH_W-1:0] ch,
                               input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                               input logic [WORD_W-1:0] word);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, word, col, row, ch};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_command(cmd, ch, row, col, word);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_register(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop sending and let every expected element and queued write drain
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // fill unwritten in-image window positions, then gather
   task automatic gather_window(input int ch, input int row, input int col);
      int y, x;
      for (int m = 0; m < sb.kh; m++) begin
         for (int n = 0; n < sb.kw; n++) begin
            y = row + m - sb.kh / 2;
            x = col + n - sb.kw / 2;
            if (sb.in_image(ch, y, x) && !sb.pixel_written[sb.addr(ch, y, x)])
               send_command(CMD_WRITE, CH_W'(ch), ROW_W'(y), COL_W'(x), $urandom());
         end
      end
      send_command(CMD_GATHER, CH_W'(ch), ROW_W'(row), COL_W'(col), $urandom());
   endtask

   // centre mostly in or near the image, sometimes anywhere
   task automatic random_gather();
      int ch, row, col;
      ch  = (sb.d > 0 && $urandom_range(4) != 0) ? $urandom_range(sb.d - 1) : $urandom_range(3);
      row = ($urandom_range(3) != 0) ? $urandom_range((sb.h + 1 > 63) ? 63 : sb.h + 1)
                                     : $urandom_range(63);
      col = ($urandom_range(3) != 0) ? $urandom_range((sb.w + 1 > 63) ? 63 : sb.w + 1)
                                     : $urandom_range(63);
      gather_window(ch, row, col);
   endtask

   task automatic random_write();
      int row, col;
      row = (sb.h > 0 && $urandom_range(1)) ? $urandom_range(sb.h - 1) : $urandom_range(63);
      col = (sb.w > 0 && $urandom_range(1)) ? $urandom_range(sb.w - 1) : $urandom_range(63);
      send_command(CMD_WRITE, CH_W'($urandom_range(3)), ROW_W'(row), COL_W'(col), $urandom());
   endtask

   // reconfigure while idle, then a burst of random commands
   task automatic run_phase(input int w, input int h, input int d, input int kw, input int kh,
                            input int count, input bit probe_spare);
      wait_idle();
      write_register(CSR_IMAGE_WIDTH, 7'(w));
      write_register(CSR_IMAGE_HEIGHT, 7'(h));
      write_register(CSR_IMAGE_DEPTH, {4'($urandom()), 3'(d)});
      write_register(CSR_KERNEL_WIDTH, {4'($urandom()), 3'(kw)});
      write_register(CSR_KERNEL_HEIGHT, {4'($urandom()), 3'(kh)});
      // indexes past the register list must be ignored
      if (probe_spare) begin
         for (int i = CSR_KERNEL_HEIGHT + 1; i < 2 ** CSR_IDX_W; i++)
            write_register(CSR_IDX_W'(i), CSR_DATA_W'($urandom()));
      end
      no_idle = ($urandom_range(3) == 0);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            wait_idle();
         if ($urandom_range(99) < 65)
            random_gather();
         else
            random_write();
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: default 32x32, one channel, 3x3 kernel
      send_command(CMD_WRITE, 0, 0, 0, 32'hFFFF_FFFF);
      send_command(CMD_WRITE, 0, 31, 31, 32'h0000_0000);
      // writes outside the image or channel range are dropped
      send_command(CMD_WRITE, 3, 63, 63, 32'hDEAD_BEEF);
      send_command(CMD_WRITE, 1, 0, 0, 32'hAAAA_AAAA);
      // corners, channel out of use, centre outside the image
      gather_window(0, 0, 0);
      gather_window(0, 31, 31);
      gather_window(2, 5, 5);
      gather_window(0, 40, 40);
      gather_window(0, 32, 10);
      gather_window(0, 63, 63);
      send_command(CMD_WRITE, 0, 5, 5, 32'h5555_5555);
      gather_window(0, 5, 5);

      // random phases across the register ranges
      run_phase(32, 32, 1, 3, 3, 15, 1'b0);
      run_phase(5, 4, 4, 3, 5, 20, 1'b1);
      run_phase(1, 1, 1, 1, 1, 10, 1'b0);
      run_phase(127, 100, 7, 7, 7, 12, 1'b0);
      run_phase(0, 0, 0, 2, 4, 8, 1'b0);
      run_phase(6, 7, 3, 0, 3, 8, 1'b0);
      run_phase(6, 7, 3, 4, 0, 6, 1'b0);
      run_phase(64, 64, 4, 7, 2, 15, 1'b0);
      run_phase(9, 3, 2, 6, 1, 15, 1'b1);
      repeat (3)
         run_phase($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 4),
                   $urandom_range(1, 7), $urandom_range(1, 7), 15, 1'b0);

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
sv/imcol_pkg.sv
sv/imcol_front.sv
sv/imcol_fifo.sv
sv/imcol_back.sv
sv/image_to_columns_window_gather_core.sv
tb/tb.sv
